FILE: rtl/abfa_pkg.sv
// Shared types, constants and helper functions of the A/B feed arbiter.
// Depends on nothing; every other file of the block but abfa_ram imports it.
`default_nettype none

package abfa_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QSUM_W = QCNT_W + 1;
	localparam int SEQ_W = 32;
	localparam int TIME_W = 48;

	localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_END = 1'b1;
	localparam logic SRC_A = 1'b0;
	localparam logic SRC_B = 1'b1;
	localparam logic STAT_FWD = 1'b0;
	localparam logic STAT_DROP = 1'b1;
	localparam int END_A = 0;
	localparam int END_B = 1;

	typedef logic [1:0] end_flags_t;

	typedef struct packed {
		logic action;
		logic source;
		logic signed [SEQ_W-1:0] sequence_req;
		logic [TIME_W-1:0] receive_time;
	} in_item_t;

	typedef struct packed {
		logic out_source;
		logic signed [SEQ_W-1:0] out_sequence;
		logic [TIME_W-1:0] out_time;
		logic status;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0] seq;
		logic [TIME_W-1:0] tim;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic push;
		logic pop;
	} queue_cmd_t;

	// True when the arbitration loop has another packet to send.
	function automatic logic emit_any(logic [QCNT_W-1:0] ca, logic [QCNT_W-1:0] cb,
			end_flags_t flags);
		logic a_has;
		logic b_has;
		a_has = (ca != '0);
		b_has = (cb != '0);
		return (a_has && b_has) || (!a_has && flags[END_A] && b_has) ||
			(!b_has && flags[END_B] && a_has);
	endfunction

	// A session is over once both feeds have ended and both queues are empty.
	function automatic end_flags_t flags_settle(end_flags_t flags, logic [QCNT_W-1:0] ca,
			logic [QCNT_W-1:0] cb);
		if (flags[END_A] && flags[END_B] && (ca == '0) && (cb == '0)) begin
			return '0;
		end
		return flags;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/abfa_ifs.sv
// Valid/ready channel interfaces for the feed arbiter's input and result streams.
// Depends on abfa_pkg for the payload types.
`default_nettype none

interface abfa_in_if
	import abfa_pkg::*;
	();
	logic valid;
	logic ready;
	in_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface abfa_out_if
	import abfa_pkg::*;
	();
	logic valid;
	logic ready;
	out_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: rtl/abfa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module abfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/abfa_queue.sv
// One feed's packet queue: head pointer, occupancy count and its storage RAM.
// Depends on abfa_pkg and abfa_ram. The head entry is read every cycle.
`default_nettype none

module abfa_queue
	import abfa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire queue_cmd_t cmd,
	input wire entry_t wr_entry,
	output logic [QCNT_W-1:0] count,
	output entry_t rd_entry
);

	logic [QPTR_W-1:0] head_q;
	logic [QCNT_W-1:0] count_q;
	logic [QSUM_W-1:0] tail_sum;
	logic [QSUM_W-1:0] tail_wrap;
	logic [QPTR_W-1:0] tail;
	logic [ENTRY_W-1:0] rd_raw;

	always_comb begin
		tail_sum = QSUM_W'(head_q) + QSUM_W'(count_q);
		tail_wrap = (tail_sum >= QSUM_W'(QUEUE_DEPTH)) ?
			(tail_sum - QSUM_W'(QUEUE_DEPTH)) : tail_sum;
		tail = tail_wrap[QPTR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			count_q <= count_q - 1'b1;
			head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		end
	end

	abfa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(cmd.push),
		.waddr(tail),
		.wdata(wr_entry),
		.raddr(head_q),
		.rdata(rd_raw)
	);

	assign count = count_q;
	assign rd_entry = entry_t'(rd_raw);

endmodule

`default_nettype wire

FILE: rtl/ab_feed_arbiter.sv
// Top level of the A/B feed arbiter: input handling, arbitration sequencer, result register.
// Depends on abfa_pkg, abfa_ifs and abfa_queue.
`default_nettype none

// The arbiter merges two sequenced feeds into one ordered stream. A packet pushed on
// feed_in is stored in its feed's 16-entry queue; an end-of-stream item marks its feed
// ended. After each accepted item the block sends every packet that has become ready on
// merged_out, the final one flagged with last; an item that frees nothing sends nothing.
// A push into a full queue is answered at once by one result with status set and last set.
// Sequence: an item is taken in ST_IDLE, and each packet it releases then passes through
// ST_READ, which reads both queue heads from their registered-read RAMs, and ST_DECIDE,
// which compares, sends and pops once the result register is free.
// A new item is taken only after the previous one's last packet is in the result
// register, while that register is empty or being emptied.

module ab_feed_arbiter
	import abfa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	abfa_in_if.sink feed_in,
	abfa_out_if.source merged_out
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	end_flags_t flags_q;
	end_flags_t flags_d;
	end_flags_t flags_new;
	out_item_t out_q;
	out_item_t out_d;
	logic out_valid_q;
	logic out_load;
	logic out_free;

	queue_cmd_t a_cmd;
	queue_cmd_t b_cmd;
	logic [QCNT_W-1:0] a_count;
	logic [QCNT_W-1:0] b_count;
	entry_t a_head;
	entry_t b_head;
	entry_t in_entry;

	logic in_acc;
	logic is_push;
	logic src_b;
	logic tgt_full;
	logic [QCNT_W-1:0] ca_n;
	logic [QCNT_W-1:0] cb_n;
	logic pick_b;
	logic pop_a;
	logic pop_b;
	logic more;

	assign out_free = !out_valid_q || merged_out.ready;
	assign feed_in.ready = (state_q == ST_IDLE) && out_free;
	assign merged_out.valid = out_valid_q;
	assign merged_out.item = out_q;

	assign in_entry.seq = feed_in.item.sequence_req;
	assign in_entry.tim = feed_in.item.receive_time;

	// Head selection for the current arbitration round.
	always_comb begin
		pick_b = 1'b0;
		pop_a = 1'b0;
		pop_b = 1'b0;
		if ((a_count != '0) && (b_count != '0)) begin
			if (a_head.seq == b_head.seq) begin
				pick_b = (a_head.tim > b_head.tim);
				pop_a = 1'b1;
				pop_b = 1'b1;
			end else if ($signed(a_head.seq) < $signed(b_head.seq)) begin
				pop_a = 1'b1;
			end else begin
				pick_b = 1'b1;
				pop_b = 1'b1;
			end
		end else if (a_count == '0) begin
			pick_b = 1'b1;
			pop_b = 1'b1;
		end else begin
			pop_a = 1'b1;
		end
	end

	always_comb begin
		in_acc = feed_in.valid && feed_in.ready;
		is_push = (feed_in.item.action == ACT_PUSH);
		src_b = (feed_in.item.source == SRC_B);
		tgt_full = src_b ? (b_count == FULL_CNT) : (a_count == FULL_CNT);

		state_d = state_q;
		flags_d = flags_q;
		flags_new = flags_q;
		out_load = 1'b0;
		out_d = out_q;
		a_cmd = '0;
		b_cmd = '0;
		ca_n = a_count;
		cb_n = b_count;
		more = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (is_push && tgt_full) begin
						out_load = 1'b1;
						out_d.out_source = feed_in.item.source;
						out_d.out_sequence = feed_in.item.sequence_req;
						out_d.out_time = feed_in.item.receive_time;
						out_d.status = STAT_DROP;
						out_d.last = 1'b1;
					end else begin
						if (is_push) begin
							a_cmd.push = !src_b;
							b_cmd.push = src_b;
							ca_n = a_count + QCNT_W'(!src_b);
							cb_n = b_count + QCNT_W'(src_b);
						end else begin
							flags_new[END_A] = flags_q[END_A] || !src_b;
							flags_new[END_B] = flags_q[END_B] || src_b;
						end
						if (emit_any(ca_n, cb_n, flags_new)) begin
							flags_d = flags_new;
							state_d = ST_READ;
						end else begin
							flags_d = flags_settle(flags_new, ca_n, cb_n);
						end
					end
				end
			end
			ST_READ: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					a_cmd.pop = pop_a;
					b_cmd.pop = pop_b;
					ca_n = a_count - QCNT_W'(pop_a);
					cb_n = b_count - QCNT_W'(pop_b);
					more = emit_any(ca_n, cb_n, flags_q);
					out_load = 1'b1;
					out_d.out_source = pick_b ? SRC_B : SRC_A;
					out_d.out_sequence = pick_b ? b_head.seq : a_head.seq;
					out_d.out_time = pick_b ? b_head.tim : a_head.tim;
					out_d.status = STAT_FWD;
					out_d.last = !more;
					if (more) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_IDLE;
						flags_d = flags_settle(flags_q, ca_n, cb_n);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flags_q <= flags_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (merged_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	abfa_queue u_queue_a (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(a_cmd),
		.wr_entry(in_entry),
		.count(a_count),
		.rd_entry(a_head)
	);

	abfa_queue u_queue_b (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(b_cmd),
		.wr_entry(in_entry),
		.count(b_count),
		.rd_entry(b_head)
	);

endmodule

`default_nettype wire

FILE: tb/sv/ab_feed_arbiter_checker.sv
// Scoreboard for the A/B feed arbiter: watches the input and result channels,
// predicts the merged stream and compares every result transfer against it.
// Depends on abfa_pkg and the channel interfaces in abfa_ifs.
`default_nettype none

module ab_feed_arbiter_checker
	import abfa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	abfa_in_if feed,
	abfa_out_if merged,
	output int mismatches,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE_A = 0;
	localparam int SIDE_B = 1;

	// Shadow copy of both packet queues and the end-of-stream flags.
	logic signed [SEQ_W-1:0] seq_mem [2][QUEUE_DEPTH];
	logic [TIME_W-1:0] time_mem [2][QUEUE_DEPTH];
	int rd_ptr [2] = '{0, 0};
	int fill [2] = '{0, 0};
	end_flags_t ended = '0;

	out_item_t merged_expected[$];

	// Queue the head of one side as a forwarded packet; pop_head pops it.
	function automatic void forward_head(int s);
		out_item_t r;
		r.out_source = (s == SIDE_B) ? SRC_B : SRC_A;
		r.out_sequence = seq_mem[s][rd_ptr[s]];
		r.out_time = time_mem[s][rd_ptr[s]];
		r.status = STAT_FWD;
		r.last = 1'b0;
		merged_expected.insert(merged_expected.size(), r);
	endfunction

	function automatic void pop_head(int s);
		rd_ptr[s] = (rd_ptr[s] + 1) % QUEUE_DEPTH;
		fill[s] = fill[s] - 1;
	endfunction

	function automatic void predict_merge(in_item_t it);
		int s;
		int slot;
		int released;
		int ha;
		int hb;
		out_item_t r;
		s = (it.source == SRC_B) ? SIDE_B : SIDE_A;
		released = 0;
		if (it.action == ACT_PUSH && fill[s] == QUEUE_DEPTH) begin
			r.out_source = it.source;
			r.out_sequence = it.sequence_req;
			r.out_time = it.receive_time;
			r.status = STAT_DROP;
			r.last = 1'b1;
			merged_expected.insert(merged_expected.size(), r);
			return;
		end
		if (it.action == ACT_PUSH) begin
			slot = (rd_ptr[s] + fill[s]) % QUEUE_DEPTH;
			seq_mem[s][slot] = it.sequence_req;
			time_mem[s][slot] = it.receive_time;
			fill[s] = fill[s] + 1;
		end else begin
			ended[(s == SIDE_B) ? END_B : END_A] = 1'b1;
		end
		forever begin
			if (fill[SIDE_A] != 0 && fill[SIDE_B] != 0) begin
				ha = rd_ptr[SIDE_A];
				hb = rd_ptr[SIDE_B];
				if (seq_mem[SIDE_A][ha] == seq_mem[SIDE_B][hb]) begin
					// Same packet on both feeds: the earlier copy goes out, A on a tie.
					forward_head((time_mem[SIDE_A][ha] <= time_mem[SIDE_B][hb]) ?
						SIDE_A : SIDE_B);
					pop_head(SIDE_A);
					pop_head(SIDE_B);
				end else if (seq_mem[SIDE_A][ha] < seq_mem[SIDE_B][hb]) begin
					forward_head(SIDE_A);
					pop_head(SIDE_A);
				end else begin
					forward_head(SIDE_B);
					pop_head(SIDE_B);
				end
			end else if (fill[SIDE_A] == 0 && ended[END_A] && fill[SIDE_B] != 0) begin
				forward_head(SIDE_B);
				pop_head(SIDE_B);
			end else if (fill[SIDE_B] == 0 && ended[END_B] && fill[SIDE_A] != 0) begin
				forward_head(SIDE_A);
				pop_head(SIDE_A);
			end else begin
				break;
			end
			released++;
		end
		if (ended[END_A] && ended[END_B] && fill[SIDE_A] == 0 && fill[SIDE_B] == 0) begin
			ended = '0;
		end
		if (released > 0) begin
			merged_expected[merged_expected.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic void show_item(string tag, out_item_t r);
		$display("%s src %0d seq %0d time %0h status %0d last %0d", tag,
			r.out_source, r.out_sequence, r.out_time, r.status, r.last);
	endfunction

	function automatic void compare_result(out_item_t got);
		out_item_t want;
		logic bad;
		if (merged_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				show_item("unexpected result:", got);
			end
		end else begin
			want = merged_expected.pop_front();
			bad = (got.out_source !== want.out_source) ||
				(got.out_sequence !== want.out_sequence) ||
				(got.out_time !== want.out_time) ||
				(got.status !== want.status) ||
				(got.last !== want.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					show_item("result mismatch: expected", want);
					show_item("                 got     ", got);
				end
			end
		end
	endfunction

	// An input transfer is predicted before a result transfer of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (feed.valid && feed.ready) begin
				predict_merge(feed.item);
			end
			if (merged.valid && merged.ready) begin
				compare_result(merged.item);
			end
			pending = merged_expected.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/ab_feed_arbiter_test.sv
// Top of the feed arbiter testbench: clock, reset, packet and end-of-stream stimulus,
// receiver back-pressure and the verdict. Depends on abfa_pkg, abfa_ifs, the block
// and ab_feed_arbiter_checker.
`default_nettype none

module ab_feed_arbiter_test
	import abfa_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIRECTED_ITEMS = 28;
	localparam int RANDOM_ITEMS = 64;

	logic clk = 1'b0;
	logic arst_n;
	int mismatches;
	int pending;
	int feed_items = 0;
	int burst_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;

	abfa_in_if feed_ch();
	abfa_out_if merged_ch();

	ab_feed_arbiter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.feed_in(feed_ch),
		.merged_out(merged_ch)
	);

	ab_feed_arbiter_checker u_merge_check (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_ch),
		.merged(merged_ch),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver back-pressure: the ready pattern follows a mode that is redrawn at random.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0) begin
			rx_mode <= $urandom_range(0, 3);
		end
		case (rx_mode)
			0: merged_ch.ready <= 1'b1;
			1: merged_ch.ready <= 1'($urandom_range(0, 1));
			2: merged_ch.ready <= (rx_cycle % 5 == 0);
			default: merged_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic in_item_t make_item(logic act, logic src, logic signed [SEQ_W-1:0] seq,
			logic [TIME_W-1:0] tim);
		in_item_t it;
		it.action = act;
		it.source = src;
		it.sequence_req = seq;
		it.receive_time = tim;
		return it;
	endfunction

	// Sender works in bursts; a gap of random length may open before each burst.
	task automatic send_item(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				feed_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		feed_ch.item <= it;
		feed_ch.valid <= 1'b1;
		do @(posedge clk); while (!feed_ch.ready);
		feed_items++;
	endtask

	// One trading session: both feeds carry mostly the same packets with their own
	// arrival jitter, interleaved with a random lead, then one ends and usually the other.
	task automatic play_session();
		in_item_t a_pkts[$];
		in_item_t b_pkts[$];
		in_item_t it;
		in_item_t tmp;
		int n;
		int bias;
		int k;
		logic lead;
		logic signed [SEQ_W-1:0] base;
		logic [TIME_W-1:0] t0;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
		case ($urandom_range(0, 4))
			0: base = 32'sh7FFF_FFF8;
			1: base = 32'sh8000_0000;
			default: base = $urandom;
		endcase
		t0 = TIME_W'({$urandom, $urandom});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) != 0) begin
				a_pkts.insert(a_pkts.size(), make_item(ACT_PUSH, SRC_A, base + i,
					t0 + i * 4 + $urandom_range(0, 3)));
			end
			if ($urandom_range(0, 9) != 0) begin
				b_pkts.insert(b_pkts.size(), make_item(ACT_PUSH, SRC_B, base + i,
					t0 + i * 4 + $urandom_range(0, 3)));
			end
		end
		// Now and then feed A delivers two packets out of order.
		if (a_pkts.size() > 1 && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, a_pkts.size() - 2);
			tmp = a_pkts[k];
			a_pkts[k] = a_pkts[k + 1];
			a_pkts[k + 1] = tmp;
		end
		bias = $urandom_range(1, 3);
		while (a_pkts.size() != 0 || b_pkts.size() != 0) begin
			if (b_pkts.size() == 0 ||
					(a_pkts.size() != 0 && $urandom_range(0, 3) < bias)) begin
				it = a_pkts.pop_front();
			end else begin
				it = b_pkts.pop_front();
			end
			send_item(it);
		end
		lead = 1'($urandom_range(0, 1));
		send_item(make_item(ACT_END, lead, '0, '0));
		if ($urandom_range(0, 2) == 0) begin
			k = $urandom_range(1, 3);
			for (int i = 0; i < k; i++) begin
				send_item(make_item(ACT_PUSH, !lead, base + n + i, t0 + (n + i) * 4));
			end
		end
		// Sometimes a session is left open and runs into the next one.
		if ($urandom_range(0, 5) != 0) begin
			send_item(make_item(ACT_END, !lead, '0, '0));
		end
	endtask

	task automatic send_noise();
		send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
			TIME_W'({$urandom, $urandom})));
	endtask

	initial begin
		arst_n <= 1'b0;
		feed_ch.valid <= 1'b0;
		feed_ch.item <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme sequence numbers: B's minimum goes first, then an equal pair
		// where B arrived earlier.
		send_item(make_item(ACT_PUSH, SRC_A, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_item(make_item(ACT_PUSH, SRC_B, 32'sh8000_0000, 48'h0));
		send_item(make_item(ACT_PUSH, SRC_B, 32'sh7FFF_FFFF, 48'h0));

		// End of A with nothing queued, pass-through on B, repeated end,
		// push after own end, then B ends and drains A.
		send_item(make_item(ACT_END, SRC_A, '0, '0));
		send_item(make_item(ACT_PUSH, SRC_B, 32'sd9, 48'h1234_5678_9ABC));
		send_item(make_item(ACT_END, SRC_A, '0, '0));
		send_item(make_item(ACT_PUSH, SRC_A, 32'sd1, 48'h8000_0000_0001));
		send_item(make_item(ACT_END, SRC_B, '0, '0));

		// Fill A, overflow it, then one B packet releases all of A with a tie at the end.
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			send_item(make_item(ACT_PUSH, SRC_A, i, 48'd7));
		end
		send_item(make_item(ACT_PUSH, SRC_A, -32'sd5, 48'hABCD_0000_0001));
		send_item(make_item(ACT_PUSH, SRC_B, QUEUE_DEPTH - 1, 48'd7));
		send_item(make_item(ACT_END, SRC_A, '0, '0));
		send_item(make_item(ACT_END, SRC_B, '0, '0));

		while (feed_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				play_session();
			end else begin
				send_noise();
			end
		end
		feed_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
